>>> rtl/core/rgbmf_pkg.sv
package rgbmf_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int PIX_W       = CHAN_W * NUM_CHAN;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int MIN_DIM     = 3;
    localparam int EDGE_SKIP   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pixel_t;

    typedef struct packed {
        pixel_t cur;
        pixel_t lower;
        pixel_t upper;
    } win_col_t;

    function automatic chan_t min2(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max2(input chan_t a, input chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sort each column of three, then take the median of the maximum of the
    // minima, the median of the middles and the minimum of the maxima.
    function automatic chan_t med9(input logic [9*CHAN_W-1:0] v);
        chan_t lo [3];
        chan_t mi [3];
        chan_t hi [3];
        chan_t a;
        chan_t b;
        chan_t c;
        for (int k = 0; k < 3; k++) begin
            a = v[(3*k)*CHAN_W +: CHAN_W];
            b = v[(3*k+1)*CHAN_W +: CHAN_W];
            c = v[(3*k+2)*CHAN_W +: CHAN_W];
            lo[k] = min2(min2(a, b), c);
            hi[k] = max2(max2(a, b), c);
            mi[k] = med3(a, b, c);
        end
        return med3(max2(max2(lo[0], lo[1]), lo[2]),
                    med3(mi[0], mi[1], mi[2]),
                    min2(min2(hi[0], hi[1]), hi[2]));
    endfunction

endpackage

>>> rtl/core/rgbmf_ram.sv
module rgbmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/rgb_median_filter_3x3_unit.sv
// RGB 3x3 median filter for a raster pixel stream.
// Pixels enter on the s_ stream channel, one request per pixel, in raster
// order. Each interior pixel yields one request on the m_ channel holding
// the per-channel median of its 3x3 neighborhood and the centre's column
// and row. Border pixels are consumed and produce no result.
// Two line memories hold the two previous lines; their read port is
// registered, so a pixel waits in the input stage while its column is
// fetched; its result is registered as it leaves that stage. Throughput
// is one pixel per clock unless the output stalls, set by the single
// read and write port of each line memory and the combinational median
// network. The user must write the image geometry through the cfg_ port
// only while the stream is idle; the block does not enforce this. Reset
// clears the position counters and the window to zero and sets both
// dimensions to 2048; line memory contents are not cleared. When
// m_tready is low the result waits in the output register; the input
// stage still takes a pixel and holds it, and s_tready falls only when a
// held pixel that yields a result cannot move into the output register.
module rgb_median_filter_3x3_unit
    import rgbmf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: red_in, green_in, blue_in.
    input  logic [23:0]            s_tdata,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: red_median, green_median, blue_median,
    // centre_col, centre_row, one pad bit.
    output logic [47:0]            m_tdata
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             a_valid_reg;
    logic             a_emit_reg;
    pixel_t           a_pix_reg;
    logic [AW-1:0]    a_idx_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [ROW_W-1:0] a_row_reg;

    win_col_t win0_reg;
    win_col_t win1_reg;
    win_col_t cur_col;

    logic        m_valid_reg;
    logic [47:0] m_data_reg;
    logic [47:0] m_data_next;

    logic          accept;
    logic          a_leave;
    logic [WW-1:0] eff_width;
    logic [ROW_W:0] eff_height;
    logic [AW-1:0] idx;
    logic [31:0]   idx_full;
    pixel_t        upper_rd;
    pixel_t        lower_rd;
    chan_t         medians [NUM_CHAN];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_DATA_W'(2048);
            height_reg <= CFG_DATA_W'(2048);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        if (32'(width_reg) < MIN_DIM) begin
            eff_width = WW'(MIN_DIM);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = WW'(width_reg);
        end
        if (32'(height_reg) < MIN_DIM) begin
            eff_height = (ROW_W + 1)'(MIN_DIM);
        end else begin
            eff_height = (ROW_W + 1)'(height_reg);
        end
    end

    assign a_leave  = a_valid_reg && (!a_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_leave;
    assign accept   = s_tvalid && s_tready;

    assign idx_full = (32'(col_reg) < MAX_WIDTH) ? 32'(col_reg) : 32'(MAX_WIDTH - 1);
    assign idx      = idx_full[AW-1:0];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (32'(col_reg) + 32'd1 >= 32'(eff_width)) begin
                col_next = '0;
                if (32'(row_reg) + 32'd1 >= 32'(eff_height)) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept) begin
                a_valid_reg <= 1'b1;
            end else if (a_leave) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg  <= s_tdata;
            a_idx_reg  <= idx;
            a_col_reg  <= col_reg;
            a_row_reg  <= row_reg;
            a_emit_reg <= (32'(row_reg) >= EDGE_SKIP) && (32'(col_reg) >= EDGE_SKIP);
        end
    end

    rgbmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_upper_ram (
        .aclk    (aclk),
        .wr_en   (a_leave),
        .wr_addr (a_idx_reg),
        .wr_data (lower_rd),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (upper_rd)
    );

    rgbmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_lower_ram (
        .aclk    (aclk),
        .wr_en   (a_leave),
        .wr_addr (a_idx_reg),
        .wr_data (a_pix_reg),
        .rd_en   (accept),
        .rd_addr (idx),
        .rd_data (lower_rd)
    );

    assign cur_col.upper = upper_rd;
    assign cur_col.lower = lower_rd;
    assign cur_col.cur   = a_pix_reg;

    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            medians[ch] = med9({win0_reg.upper[ch*CHAN_W +: CHAN_W],
                                win0_reg.lower[ch*CHAN_W +: CHAN_W],
                                win0_reg.cur[ch*CHAN_W +: CHAN_W],
                                win1_reg.upper[ch*CHAN_W +: CHAN_W],
                                win1_reg.lower[ch*CHAN_W +: CHAN_W],
                                win1_reg.cur[ch*CHAN_W +: CHAN_W],
                                cur_col.upper[ch*CHAN_W +: CHAN_W],
                                cur_col.lower[ch*CHAN_W +: CHAN_W],
                                cur_col.cur[ch*CHAN_W +: CHAN_W]});
        end
        m_data_next = {1'b0,
                       a_row_reg - ROW_W'(1),
                       a_col_reg - COL_W'(1),
                       medians[2], medians[1], medians[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win0_reg    <= '0;
            win1_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_leave) begin
                win0_reg <= win1_reg;
                win1_reg <= cur_col;
            end
            if (a_leave && a_emit_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_leave && a_emit_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
